### rtl/core/sqlsl_pkg.sv
// ----------------------------------------------------------------------------
// sqlsl_pkg
// Shared types, character codes and the command keyword table of the SQL
// statement locator.
// ----------------------------------------------------------------------------
package sqlsl_pkg;

	typedef logic [7:0] char_t;
	typedef char_t [7:0] window_t;          // [0] current char, [7] furthest ahead

	typedef enum logic [1:0] {
		MODE_PLAIN   = 2'd0,
		MODE_STRING  = 2'd1,
		MODE_COMMENT = 2'd2
	} scan_mode_t;

	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_NEWLINE,
		ACT_SKIP,
		ACT_STR_OPEN,
		ACT_STR_CLOSE,
		ACT_LINE_CMT,
		ACT_BLK_OPEN,
		ACT_BLK_CLOSE,
		ACT_KEYWORD,
		ACT_OTHER
	} action_t;

	localparam logic [1:0] ST_BOUNDED      = 2'd0;
	localparam logic [1:0] ST_UNTERMINATED = 2'd1;
	localparam logic [1:0] ST_PAST_CURSOR  = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND    = 2'd3;

	localparam int OUT_POS_W = 16;

	typedef struct packed {
		logic                 valid;
		logic [1:0]           status;
		logic [OUT_POS_W-1:0] span_start;
		logic [OUT_POS_W-1:0] span_end;
	} scan_res_t;

	localparam char_t CH_NL    = 8'h0A;
	localparam char_t CH_QUOTE = 8'h27;
	localparam char_t CH_STAR  = 8'h2A;
	localparam char_t CH_DASH  = 8'h2D;
	localparam char_t CH_SLASH = 8'h2F;
	localparam char_t CH_SEMI  = 8'h3B;

	localparam int KW_COUNT = 17;

	// Keyword text, first char in the top byte, padded with spaces to 8 chars.
	localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
		"CREATE  ", "ALTER   ", "DROP    ", "SELECT  ", "PRAGMA  ", "COMMIT  ",
		"ROLLBACK", "BEGIN   ", "VACUUM  ", "ATTACH  ", "DETACH  ", "ANALYZE ",
		"REINDEX ", "INSERT  ", "UPDATE  ", "DELETE  ", "REPLACE "
	};

	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd6, 4'd5, 4'd4, 4'd6, 4'd6, 4'd6, 4'd8, 4'd5, 4'd6,
		4'd6, 4'd6, 4'd7, 4'd7, 4'd6, 4'd6, 4'd6, 4'd7
	};

	function automatic char_t upper_ascii(input char_t c);
		char_t r;
		r = c;
		if (c inside {[8'h61:8'h7A]}) begin
			r = c - 8'd32;
		end
		return r;
	endfunction

endpackage

### rtl/core/sql_statement_locator_top.sv
// ----------------------------------------------------------------------------
// sql_statement_locator_top
// Streaming SQL statement locator: one character per item, reports the
// statement span that holds the configured cursor once per text.
// ----------------------------------------------------------------------------
// Pipeline: an accepted input item passes through the input register, then the
//   result register, before its result shows on m_tvalid.
// Throughput: one item per cycle; a result held by m_tready low stalls input
//   once the input register is full too.
// Reset (arst_n low, asynchronous): pipeline emptied, scan state back to plain
//   mode at position 0, cursor_position cleared to 0.
module sql_statement_locator_top #(
	parameter int POSITION_BITS = 16    // position counter width, 8..32
) (
	input  logic        clk,
	input  logic        arst_n,
	// character items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,        // char_now, ahead_1 .. ahead_7 (8 bits each)
	input  logic        s_tlast,        // last_char
	// span results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,        // status(2), span_start(16), span_end(16), zero pad
	// cursor_position register write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);
	import sqlsl_pkg::*;

	// input register
	logic      s1_valid_q;
	window_t   win_s1;
	logic      last_s1;

	// result register
	logic      m_valid_q;
	scan_res_t res_q;

	logic                 cfg_acc;
	logic [OUT_POS_W-1:0] cursor_pos_q;
	scan_res_t            res;
	logic                 out_free, fire, s_acc;

	// cursor register; the sender must write it only while no item is in flight (not enforced here)
	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_pos_q <= '0;
		end else if (cfg_acc) begin
			cursor_pos_q <= cfg_data;
		end
	end

	// the item in the input register is processed once the result register
	// can take whatever it yields
	assign out_free = !m_valid_q || m_tready;
	assign fire     = s1_valid_q && out_free;
	assign s_tready = !s1_valid_q || out_free;
	assign s_acc    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_acc) begin
			s1_valid_q <= 1'b1;
		end else if (fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			win_s1  <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	sqlsl_scan_core #(
		.POSITION_BITS (POSITION_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.win    (win_s1),
		.last   (last_s1),
		.cursor (cursor_pos_q),
		.res    (res)
	);

	// result register; most characters yield nothing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (fire && res.valid) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res.valid) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'd0, res_q.span_end, res_q.span_start, res_q.status};

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !fire |=> s1_valid_q && $stable(win_s1) && $stable(last_s1))
		else $error("input register overwritten before processing");

	a_past_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && res_q.status == ST_PAST_CURSOR |-> res_q.span_end == '0)
		else $error("past-cursor result with non-zero end");

endmodule

### rtl/core/sqlsl_keyword_match.sv
// ----------------------------------------------------------------------------
// sqlsl_keyword_match
// Case-insensitive prefix compare of the lookahead window against the
// command keyword table.
// ----------------------------------------------------------------------------
module sqlsl_keyword_match (
	input  sqlsl_pkg::window_t win,
	output logic               hit
);
	import sqlsl_pkg::*;

	logic [KW_COUNT-1:0] kw_ok;

	// one compare per keyword and window byte, all independent
	always_comb begin
		for (int k = 0; k < KW_COUNT; k++) begin
			kw_ok[k] = 1'b1;
			for (int i = 0; i < 8; i++) begin
				if (4'(i) < KW_LEN[k] &&
				    upper_ascii(win[i]) != KW_TEXT[k][63-8*i -: 8]) begin
					kw_ok[k] = 1'b0;
				end
			end
		end
	end

	assign hit = |kw_ok;

endmodule

### rtl/core/sqlsl_scan_core.sv
// ----------------------------------------------------------------------------
// sqlsl_scan_core
// Per-character scan state: mode tracking, statement open/close and the
// one-shot span report.
// ----------------------------------------------------------------------------
module sqlsl_scan_core #(
	parameter int POSITION_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fire,
	input  sqlsl_pkg::window_t           win,
	input  logic                         last,
	input  logic [sqlsl_pkg::OUT_POS_W-1:0] cursor,
	output sqlsl_pkg::scan_res_t         res
);
	import sqlsl_pkg::*;

	localparam int CMP_W = (POSITION_BITS > OUT_POS_W) ? POSITION_BITS : OUT_POS_W;

	scan_mode_t               mode_q, mode_step;
	logic                     skip_q, skip_step;
	logic                     stmt_q, stmt_step;
	logic [POSITION_BITS-1:0] open_q, open_step;
	logic [POSITION_BITS-1:0] close_q, close_step;
	logic [POSITION_BITS-1:0] cnt_q, cnt_step;
	logic                     rep_q, rep_step;

	logic             kw_hit;
	action_t          act;
	char_t            c, nx;
	logic [CMP_W-1:0] p_w, cur_w, open_w, close_w, open_step_w, close_step_w;
	logic             past_cursor, in_span;

	sqlsl_keyword_match u_kw (
		.win (win),
		.hit (kw_hit)
	);

	assign c            = win[0];
	assign nx           = win[1];
	assign p_w          = CMP_W'(cnt_q);
	assign cur_w        = CMP_W'(cursor);
	assign open_w       = CMP_W'(open_q);
	assign close_w      = CMP_W'(close_q);
	assign open_step_w  = CMP_W'(open_step);
	assign close_step_w = CMP_W'(close_step);
	assign past_cursor  = p_w > cur_w;
	assign in_span      = (open_w <= cur_w) && (cur_w <= close_step_w);

	// priority decode of what this char does
	always_comb begin
		if (rep_q) begin
			act = ACT_NONE;
		end else if (c == CH_NL) begin
			act = ACT_NEWLINE;
		end else if (skip_q) begin
			act = ACT_SKIP;
		end else if (mode_q == MODE_PLAIN && c == CH_QUOTE) begin
			act = ACT_STR_OPEN;
		end else if (mode_q == MODE_STRING && c == CH_QUOTE) begin
			act = ACT_STR_CLOSE;
		end else if (mode_q == MODE_PLAIN && c == CH_DASH && nx == CH_DASH) begin
			act = ACT_LINE_CMT;
		end else if (mode_q == MODE_PLAIN && c == CH_SLASH && nx == CH_STAR) begin
			act = ACT_BLK_OPEN;
		end else if (mode_q == MODE_COMMENT && c == CH_STAR && nx == CH_SLASH) begin
			act = ACT_BLK_CLOSE;
		end else if (mode_q == MODE_PLAIN && !stmt_q && kw_hit) begin
			act = ACT_KEYWORD;
		end else begin
			act = ACT_OTHER;
		end
	end

	// next state, before the end-of-text clear
	always_comb begin
		mode_step  = mode_q;
		skip_step  = skip_q;
		stmt_step  = stmt_q;
		open_step  = open_q;
		close_step = close_q;
		rep_step   = rep_q;
		cnt_step   = (cnt_q != '1) ? cnt_q + 1'b1 : cnt_q;
		case (act)
			ACT_NEWLINE:   skip_step = 1'b0;
			ACT_STR_OPEN:  mode_step = MODE_STRING;
			ACT_STR_CLOSE: mode_step = MODE_PLAIN;
			ACT_LINE_CMT:  skip_step = 1'b1;
			ACT_BLK_OPEN:  mode_step = MODE_COMMENT;
			ACT_BLK_CLOSE: mode_step = MODE_PLAIN;
			ACT_KEYWORD: begin
				stmt_step = 1'b1;
				if (past_cursor) begin
					rep_step = 1'b1;
				end else begin
					open_step  = cnt_q;
					close_step = '0;
				end
			end
			ACT_OTHER: begin
				if (mode_q == MODE_PLAIN && stmt_q && c == CH_SEMI) begin
					stmt_step  = 1'b0;
					close_step = cnt_q;
				end
				if ((open_w <= cur_w) && (cur_w <= ((mode_q == MODE_PLAIN && stmt_q &&
				    c == CH_SEMI) ? p_w : close_w))) begin
					rep_step = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// result
	always_comb begin
		res = '0;
		case (act)
			ACT_KEYWORD: begin
				if (past_cursor) begin
					res.valid      = 1'b1;
					res.status     = ST_PAST_CURSOR;
					res.span_start = OUT_POS_W'(p_w);
				end
			end
			ACT_OTHER: begin
				if (in_span) begin
					res.valid      = 1'b1;
					res.status     = ST_BOUNDED;
					res.span_start = OUT_POS_W'(open_w);
					res.span_end   = OUT_POS_W'(close_step_w);
				end
			end
			default: ;
		endcase
		if (last && !rep_step) begin
			res.valid      = 1'b1;
			res.span_start = OUT_POS_W'(open_step_w);
			if (stmt_step) begin
				res.status   = ST_UNTERMINATED;
				res.span_end = OUT_POS_W'(p_w);
			end else begin
				res.status   = ST_NOT_FOUND;
				res.span_end = OUT_POS_W'(close_step_w);
			end
		end
		if (!fire) begin
			res.valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_PLAIN;
			skip_q  <= 1'b0;
			stmt_q  <= 1'b0;
			open_q  <= '0;
			close_q <= '0;
			cnt_q   <= '0;
			rep_q   <= 1'b0;
		end else if (fire) begin
			if (last) begin
				mode_q  <= MODE_PLAIN;
				skip_q  <= 1'b0;
				stmt_q  <= 1'b0;
				open_q  <= '0;
				close_q <= '0;
				cnt_q   <= '0;
				rep_q   <= 1'b0;
			end else begin
				mode_q  <= mode_step;
				skip_q  <= skip_step;
				stmt_q  <= stmt_step;
				open_q  <= open_step;
				close_q <= close_step;
				cnt_q   <= cnt_step;
				rep_q   <= rep_step;
			end
		end
	end

	a_res_only_on_fire: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> fire)
		else $error("result without a processed item");

	a_silent_after_report: assert property (@(posedge clk) disable iff (!arst_n)
		fire && rep_q && !last |-> !res.valid)
		else $error("second report within one text");

	a_text_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last |=> cnt_q == '0 && !rep_q && !stmt_q)
		else $error("scan state not cleared after last char");

	a_last_reports: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last && !rep_q |-> res.valid)
		else $error("no report for an unreported text");

endmodule
